/* src/kict_pkg.sv */
// package for the keyed item count table
// holds field widths, request and status codes and the cell control struct
// no dependencies
package kict_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 48;
    localparam int CNT_W        = 32;
    localparam int AMT_W        = 16;
    localparam int REQ_W        = 3;
    localparam int STAT_W       = 2;
    localparam int POS_OUT_W    = 6;
    localparam int USED_OUT_W   = 7;
    // wide enough for a fill level of the largest supported capacity
    localparam int IDX_W        = 11;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_STOCK_IN  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOCK_OUT = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP       = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    typedef struct packed {
        logic             cmp_en;
        logic [1:0]       op;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] fill;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } t_cell_ctrl;

endpackage

/* src/kict_cell.sv */
// one table entry: key and count storage, key compare, shift from the next cell
// depends on kict_pkg
module kict_cell #(
    parameter int Idx = 0
) (
    input  logic                      i_clk,
    input  kict_pkg::t_cell_ctrl      i_ctrl,
    input  logic [kict_pkg::KEY_W-1:0] i_code,
    input  logic [kict_pkg::KEY_W-1:0] i_nb_key,
    input  logic [kict_pkg::CNT_W-1:0] i_nb_cnt,
    output logic [kict_pkg::KEY_W-1:0] o_key,
    output logic [kict_pkg::CNT_W-1:0] o_cnt,
    output logic                      o_match
);
    import kict_pkg::*;

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(Idx);

    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_cnt;
    logic             r_match;
    logic             w_valid;

    assign w_valid = (MyIdx < i_ctrl.fill);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= w_valid && (r_key == i_code);
        end
        case (i_ctrl.op)
            OP_LOAD: begin
                if (MyIdx == i_ctrl.fill) begin
                    r_key <= i_ctrl.key;
                    r_cnt <= i_ctrl.cnt;
                end
            end
            OP_SHIFT: begin
                // close the gap: every entry from the removed one up moves down
                if (MyIdx >= i_ctrl.pos) begin
                    r_key <= i_nb_key;
                    r_cnt <= i_nb_cnt;
                end
            end
            OP_COUNT: begin
                if (MyIdx == i_ctrl.pos) begin
                    r_cnt <= i_ctrl.cnt;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_cnt   = r_cnt;
    assign o_match = r_match;

endmodule

/* src/kict_enc.sv */
// turns the one-hot match row into hit, position and the matched count
// depends on kict_pkg
module kict_enc #(
    parameter int Capacity = kict_pkg::CAPACITY_DEF,
    parameter int PosW     = $clog2(Capacity)
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [Capacity-1:0]        i_match,
    input  logic [kict_pkg::CNT_W-1:0] i_cnt [Capacity],
    output logic                       o_hit,
    output logic [PosW-1:0]            o_pos,
    output logic [kict_pkg::CNT_W-1:0] o_cnt
);
    import kict_pkg::*;

    logic             r_hit;
    logic [PosW-1:0]  r_pos;
    logic [CNT_W-1:0] r_cnt;
    logic [PosW-1:0]  n_pos;
    logic [CNT_W-1:0] n_cnt;

    // keys are unique among valid entries, so at most one match bit is set
    always_comb begin
        n_pos = '0;
        n_cnt = '0;
        for (int i = 0; i < Capacity; i++) begin
            if (i_match[i]) begin
                n_pos = n_pos | PosW'(i);
                n_cnt = n_cnt | i_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= |i_match;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
        end
    end

    assign o_hit = r_hit;
    assign o_pos = r_pos;
    assign o_cnt = r_cnt;

endmodule

/* src/keyed_item_count_table.sv */
// keyed item count table top level: control sequencer, fill level, result register
// depends on kict_pkg, kict_cell and kict_enc
//
// usage
//   request channel: i_valid / o_ready with i_req_type, i_item_code, i_amount
//   result channel:  o_valid / i_ready with o_status, o_entry_pos, o_count_now,
//   o_entries_used; every request beat gives exactly one result beat
// timing
//   a request is taken in the idle cycle; every cell compares its key against
//   the code at that edge, the next cycle encodes the match row into position
//   and count, then the update state writes the row of cells (load, count
//   write or one-step shift down on remove) and loads the result register,
//   holding while an earlier result is not yet taken; a new request is taken
//   only once the update of the one before it is done
//   the compare, encode and update steps run in that order through the row
// reset
//   fill level cleared, table empty; stored keys and counts are not cleared
// stall
//   a new request is taken while an earlier result still waits; its update
//   holds until the result register is free, so no result is lost
module keyed_item_count_table #(
    parameter int CAPACITY = kict_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [kict_pkg::REQ_W-1:0]      i_req_type,
    input  logic [kict_pkg::KEY_W-1:0]      i_item_code,
    input  logic [kict_pkg::AMT_W-1:0]      i_amount,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [kict_pkg::STAT_W-1:0]     o_status,
    output logic [kict_pkg::POS_OUT_W-1:0]  o_entry_pos,
    output logic signed [kict_pkg::CNT_W-1:0] o_count_now,
    output logic [kict_pkg::USED_OUT_W-1:0] o_entries_used
);
    import kict_pkg::*;

    localparam int PosW  = $clog2(CAPACITY);
    localparam int FillW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ENC  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [FillW-1:0] r_fill, n_fill;
    logic [REQ_W-1:0] r_req;
    logic [KEY_W-1:0] r_code;
    logic [AMT_W-1:0] r_amt;

    logic             r_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             w_accept;
    logic             w_upd_go;
    logic             w_full;
    t_cell_ctrl       w_ctrl;

    logic [CAPACITY-1:0] w_match;
    logic [KEY_W-1:0]    w_key [CAPACITY];
    logic [CNT_W-1:0]    w_cnt [CAPACITY];
    logic [KEY_W-1:0]    w_nb_key [CAPACITY];
    logic [CNT_W-1:0]    w_nb_cnt [CAPACITY];

    logic             w_hit;
    logic [PosW-1:0]  w_hpos;
    logic [CNT_W-1:0] w_hcnt;

    logic [CNT_W+1:0] w_sum;
    logic [CNT_W-1:0] w_sat;
    logic             w_sat_hi;
    logic             w_sat_lo;

    logic [15:0]      w_pos_ext;
    logic [15:0]      w_fill_ext;

    assign o_ready  = (r_state == S_IDLE) && i_rst_n;
    assign w_accept = i_valid && o_ready;
    assign w_upd_go = (r_state == S_UPD) && (!r_out_valid || i_ready);
    assign w_full   = (r_fill >= FillW'(CAPACITY));

    // saturating add or subtract of the amount on the matched count
    always_comb begin
        if (r_req == REQ_STOCK_OUT) begin
            w_sum = {{2{w_hcnt[CNT_W-1]}}, w_hcnt} - {{(CNT_W+2-AMT_W){1'b0}}, r_amt};
        end else begin
            w_sum = {{2{w_hcnt[CNT_W-1]}}, w_hcnt} + {{(CNT_W+2-AMT_W){1'b0}}, r_amt};
        end
        w_sat_hi = !w_sum[CNT_W+1] && (w_sum[CNT_W] || w_sum[CNT_W-1]);
        w_sat_lo = w_sum[CNT_W+1] && !(w_sum[CNT_W] && w_sum[CNT_W-1]);
        if (w_sat_hi) begin
            w_sat = {1'b0, {(CNT_W-1){1'b1}}};
        end else if (w_sat_lo) begin
            w_sat = {1'b1, {(CNT_W-1){1'b0}}};
        end else begin
            w_sat = w_sum[CNT_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_status = ST_OK;
        n_pos    = '0;
        n_cnt    = '0;
        w_ctrl.cmp_en = w_accept;
        w_ctrl.op     = OP_NONE;
        w_ctrl.pos    = IDX_W'(w_hpos);
        w_ctrl.fill   = IDX_W'(r_fill);
        w_ctrl.key    = r_code;
        w_ctrl.cnt    = w_sat;

        case (r_req)
            REQ_INSERT: begin
                if (w_hit) begin
                    n_status = ST_DUP;
                    n_pos    = w_hpos;
                    n_cnt    = w_hcnt;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos       = PosW'(r_fill);
                    n_cnt       = CNT_W'(r_amt);
                    w_ctrl.op   = OP_LOAD;
                    w_ctrl.cnt  = CNT_W'(r_amt);
                    n_fill      = r_fill + FillW'(1);
                end
            end
            REQ_REMOVE: begin
                if (w_hit) begin
                    n_pos     = w_hpos;
                    w_ctrl.op = OP_SHIFT;
                    n_fill    = r_fill - FillW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            REQ_LOOKUP: begin
                if (w_hit) begin
                    n_pos = w_hpos;
                    n_cnt = w_hcnt;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            REQ_STOCK_IN, REQ_STOCK_OUT: begin
                if (w_hit) begin
                    n_pos     = w_hpos;
                    n_cnt     = w_sat;
                    w_ctrl.op = OP_COUNT;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase

        if (!w_upd_go) begin
            w_ctrl.op = OP_NONE;
            n_fill    = r_fill;
        end

        case (r_state)
            S_IDLE:  n_state = w_accept ? S_ENC : S_IDLE;
            S_ENC:   n_state = S_UPD;
            S_UPD:   n_state = w_upd_go ? S_IDLE : S_UPD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_upd_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_code <= i_item_code;
            r_amt  <= i_amount;
        end
        if (w_upd_go) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
        end
    end

    // row of cells; on a remove shift each cell from the removed entry up takes its upper neighbor's entry
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_last
            assign w_nb_key[g] = '0;
            assign w_nb_cnt[g] = '0;
        end else begin : g_mid
            assign w_nb_key[g] = w_key[g+1];
            assign w_nb_cnt[g] = w_cnt[g+1];
        end

        kict_cell #(
            .Idx (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_code   (i_item_code),
            .i_nb_key (w_nb_key[g]),
            .i_nb_cnt (w_nb_cnt[g]),
            .o_key    (w_key[g]),
            .o_cnt    (w_cnt[g]),
            .o_match  (w_match[g])
        );
    end

    kict_enc #(
        .Capacity (CAPACITY),
        .PosW     (PosW)
    ) u_enc (
        .i_clk   (i_clk),
        .i_en    (r_state == S_ENC),
        .i_match (w_match),
        .i_cnt   (w_cnt),
        .o_hit   (w_hit),
        .o_pos   (w_hpos),
        .o_cnt   (w_hcnt)
    );

    assign w_pos_ext  = 16'(r_pos);
    assign w_fill_ext = 16'(r_fill);

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_entry_pos    = w_pos_ext[POS_OUT_W-1:0];
    assign o_count_now    = r_cnt;
    assign o_entries_used = w_fill_ext[USED_OUT_W-1:0];

endmodule
